// ----- sv/rt3d_pkg.sv -----
package rt3d_pkg;

    // Field widths
    localparam int COORD_W   = 32;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = COEF_W - 2;
    localparam int COL_W     = 3 * COEF_W;

    // Datapath widths: difference, product, accumulator, rounded value
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = DIFF_W + COEF_W;
    localparam int ACC_W   = PROD_W + 3;
    localparam int RND_W   = ACC_W - COEF_FRAC;

    // APB port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [RND_W-1:0]   rnd_t;
    typedef logic [COL_W-1:0]          col_t;

    typedef enum logic [2:0] {
        REG_COL0 = 3'd0,
        REG_COL1 = 3'd1,
        REG_COL2 = 3'd2,
        REG_OFFX = 3'd3,
        REG_OFFY = 3'd4,
        REG_OFFZ = 3'd5
    } reg_idx_t;

    // Reset matrix is the identity
    localparam col_t COL0_RST = col_t'(1) << COEF_FRAC;
    localparam col_t COL1_RST = col_t'(1) << (COEF_FRAC + COEF_W);
    localparam col_t COL2_RST = col_t'(1) << (COEF_FRAC + 2 * COEF_W);

    localparam acc_t ROUND_HALF = acc_t'(1) <<< (COEF_FRAC - 1);

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Load enables of the lane stages
    typedef struct packed {
        logic prod;
        logic sum;
        logic result;
    } stage_en_t;

    function automatic coef_t coef_of(input col_t col, input logic [1:0] row);
        coef_t c;
        c = col[row*COEF_W +: COEF_W];
        return c;
    endfunction

endpackage

// ----- sv/rt3d_regs.sv -----
module rt3d_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rt3d_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rt3d_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rt3d_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output rt3d_pkg::col_t   [2:0]               matrix_col,
    output rt3d_pkg::coord_t [2:0]               offset
);

    rt3d_pkg::col_t   [2:0] col_reg;
    rt3d_pkg::coord_t [2:0] off_reg;
    rt3d_pkg::reg_idx_t     idx;
    logic                   wr;

    assign idx    = rt3d_pkg::reg_idx_t'(paddr[5:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg[0] <= rt3d_pkg::COL0_RST;
            col_reg[1] <= rt3d_pkg::COL1_RST;
            col_reg[2] <= rt3d_pkg::COL2_RST;
            off_reg    <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                rt3d_pkg::REG_COL0: col_reg[0] <= pwdata[rt3d_pkg::COL_W-1:0];
                rt3d_pkg::REG_COL1: col_reg[1] <= pwdata[rt3d_pkg::COL_W-1:0];
                rt3d_pkg::REG_COL2: col_reg[2] <= pwdata[rt3d_pkg::COL_W-1:0];
                rt3d_pkg::REG_OFFX: off_reg[0] <= pwdata[rt3d_pkg::COORD_W-1:0];
                rt3d_pkg::REG_OFFY: off_reg[1] <= pwdata[rt3d_pkg::COORD_W-1:0];
                rt3d_pkg::REG_OFFZ: off_reg[2] <= pwdata[rt3d_pkg::COORD_W-1:0];
                default: ;  // drop writes beyond the map
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            rt3d_pkg::REG_COL0: prdata = rt3d_pkg::APB_DATA_W'(col_reg[0]);
            rt3d_pkg::REG_COL1: prdata = rt3d_pkg::APB_DATA_W'(col_reg[1]);
            rt3d_pkg::REG_COL2: prdata = rt3d_pkg::APB_DATA_W'(col_reg[2]);
            rt3d_pkg::REG_OFFX: prdata = rt3d_pkg::APB_DATA_W'(unsigned'(off_reg[0]));
            rt3d_pkg::REG_OFFY: prdata = rt3d_pkg::APB_DATA_W'(unsigned'(off_reg[1]));
            rt3d_pkg::REG_OFFZ: prdata = rt3d_pkg::APB_DATA_W'(unsigned'(off_reg[2]));
            default:            prdata = '0;
        endcase
    end

    assign matrix_col = col_reg;
    assign offset     = off_reg;

endmodule

// ----- sv/rt3d_lane.sv -----
module rt3d_lane (
    input  logic                           clk,
    input  rt3d_pkg::stage_en_t            en,
    input  rt3d_pkg::diff_t  [2:0]         operand,
    input  rt3d_pkg::coef_t  [2:0]         coef,
    input  rt3d_pkg::coord_t               add_term,
    output rt3d_pkg::coord_t               result
);

    rt3d_pkg::prod_t [2:0] prod_reg;
    rt3d_pkg::prod_t [2:0] prod_next;
    rt3d_pkg::coord_t      add_reg;
    rt3d_pkg::acc_t        sum_reg;
    rt3d_pkg::acc_t        sum_next;
    rt3d_pkg::coord_t      result_reg;
    rt3d_pkg::coord_t      result_next;
    rt3d_pkg::rnd_t        rnd;

    // Stage 2: one multiply per term
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_next[k] = operand[k] * coef[k];
        end
    end

    // Stage 3: sum terms, scaled offset and the half LSB
    always_comb
    begin
        sum_next = rt3d_pkg::acc_t'(prod_reg[0]) + rt3d_pkg::acc_t'(prod_reg[1])
                 + rt3d_pkg::acc_t'(prod_reg[2])
                 + (rt3d_pkg::acc_t'(add_reg) <<< rt3d_pkg::COEF_FRAC)
                 + rt3d_pkg::ROUND_HALF;
    end

    // Stage 4: floor to output scale, then saturate
    always_comb
    begin
        rnd = rt3d_pkg::rnd_t'(sum_reg >>> rt3d_pkg::COEF_FRAC);
        if (rnd > rt3d_pkg::rnd_t'(rt3d_pkg::COORD_MAX))
        begin
            result_next = rt3d_pkg::COORD_MAX;
        end
        else if (rnd < rt3d_pkg::rnd_t'(rt3d_pkg::COORD_MIN))
        begin
            result_next = rt3d_pkg::COORD_MIN;
        end
        else
        begin
            result_next = rt3d_pkg::coord_t'(rnd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            prod_reg <= prod_next;
            add_reg  <= add_term;
        end
        if (en.sum)
        begin
            sum_reg <= sum_next;
        end
        if (en.result)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- sv/rigid_transform_ray_3d.sv -----
// A taken request passes the operand-select, multiply, sum and round-and-saturate
// registers in that order; its result then shows on out_valid.
// Throughput: one request per cycle while in_stall is low; four register
// stages (operand select, multiply, three-term sum, round and saturate) each
// hold one request. Stages advance independently; bubbles close up under out_stall.
// Reset (rst_n, async, active low): pipeline empties, M returns to identity,
// offset returns to zero.
module rigid_transform_ray_3d (
    input  logic                             clk,
    input  logic                             rst_n,
    // APB configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rt3d_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rt3d_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rt3d_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    // Ray requests
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             operation,
    input  logic signed [rt3d_pkg::COORD_W-1:0] pos_x,
    input  logic signed [rt3d_pkg::COORD_W-1:0] pos_y,
    input  logic signed [rt3d_pkg::COORD_W-1:0] pos_z,
    input  logic signed [rt3d_pkg::COORD_W-1:0] vel_x,
    input  logic signed [rt3d_pkg::COORD_W-1:0] vel_y,
    input  logic signed [rt3d_pkg::COORD_W-1:0] vel_z,
    // Transformed rays
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [rt3d_pkg::COORD_W-1:0] out_pos_x,
    output logic signed [rt3d_pkg::COORD_W-1:0] out_pos_y,
    output logic signed [rt3d_pkg::COORD_W-1:0] out_pos_z,
    output logic signed [rt3d_pkg::COORD_W-1:0] out_vel_x,
    output logic signed [rt3d_pkg::COORD_W-1:0] out_vel_y,
    output logic signed [rt3d_pkg::COORD_W-1:0] out_vel_z
);

    rt3d_pkg::col_t   [2:0] matrix_col;
    rt3d_pkg::coord_t [2:0] offset;

    rt3d_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .matrix_col (matrix_col),
        .offset     (offset)
    );

    // Valid bits of stages 1..4; stage 4 is the output register.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    rt3d_pkg::stage_en_t lane_en;

    // A stage loads when it is empty or the stage after it moves on.
    assign en4 = !v4_reg || !out_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign in_stall  = !en1;
    assign out_valid = v4_reg;

    assign lane_en.prod   = en2;
    assign lane_en.sum    = en3;
    assign lane_en.result = en4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: operands, coefficient routing and offset term.
    // Forward uses M^T on (p - d); reverse uses M on p and adds d afterward.
    rt3d_pkg::coord_t [2:0]      pos_in;
    rt3d_pkg::coord_t [2:0]      vel_in;
    rt3d_pkg::diff_t  [2:0]      pos_op_next, pos_op_reg;
    rt3d_pkg::diff_t  [2:0]      vel_op_next, vel_op_reg;
    rt3d_pkg::coef_t  [2:0][2:0] coef_next, coef_reg;   // [lane][term]
    rt3d_pkg::coord_t [2:0]      add_next, add_reg;

    assign pos_in = {pos_z, pos_y, pos_x};
    assign vel_in = {vel_z, vel_y, vel_x};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            vel_op_next[k] = rt3d_pkg::diff_t'(vel_in[k]);
            if (operation)
            begin
                pos_op_next[k] = rt3d_pkg::diff_t'(pos_in[k]);
                add_next[k]    = offset[k];
            end
            else
            begin
                pos_op_next[k] = rt3d_pkg::diff_t'(pos_in[k]) - rt3d_pkg::diff_t'(offset[k]);
                add_next[k]    = '0;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (operation)
                begin
                    // M[i][k]: row i of column k
                    coef_next[i][k] = rt3d_pkg::coef_of(matrix_col[k], 2'(i));
                end
                else
                begin
                    // M[k][i]: row k of column i
                    coef_next[i][k] = rt3d_pkg::coef_of(matrix_col[i], 2'(k));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            pos_op_reg <= pos_op_next;
            vel_op_reg <= vel_op_next;
            coef_reg   <= coef_next;
            add_reg    <= add_next;
        end
    end

    // Stages 2..4: one lane per output component.
    rt3d_pkg::coord_t [2:0] pos_res;
    rt3d_pkg::coord_t [2:0] vel_res;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        rt3d_lane u_pos (
            .clk      (clk),
            .en       (lane_en),
            .operand  (pos_op_reg),
            .coef     (coef_reg[i]),
            .add_term (add_reg[i]),
            .result   (pos_res[i])
        );

        rt3d_lane u_vel (
            .clk      (clk),
            .en       (lane_en),
            .operand  (vel_op_reg),
            .coef     (coef_reg[i]),
            .add_term ('0),
            .result   (vel_res[i])
        );
    end

    assign out_pos_x = pos_res[0];
    assign out_pos_y = pos_res[1];
    assign out_pos_z = pos_res[2];
    assign out_vel_x = vel_res[0];
    assign out_vel_y = vel_res[1];
    assign out_vel_z = vel_res[2];

endmodule
